FILE: sv/cpr_pkg.sv
`default_nettype none

package cpr_pkg;

    // Fixed field widths of the block.
    localparam int CFG_W   = 5;
    localparam int SLOT_W  = 4;
    localparam int FAULT_W = 16;
    localparam int APB_W   = 32;
    localparam int ADDR_W  = 3;

    // Register map, by word index.
    localparam logic REG_FRAMES = 1'b0;

    localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd3;

    // Sequencer controls from the top level.
    typedef struct packed {
        logic start;
        logic out_free;
    } cpr_ctrl_t;

    // Sequencer status to the top level.
    typedef struct packed {
        logic ready;
        logic done;
    } cpr_status_t;

    // One finished result.
    typedef struct packed {
        logic               page_fault;
        logic [SLOT_W-1:0]  frame_slot;
        logic [FAULT_W-1:0] fault_total;
    } cpr_result_t;

endpackage

`default_nettype wire

FILE: sv/cpr_page_ram.sv
`default_nettype none

module cpr_page_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = 4
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: sv/cpr_engine.sv
`default_nettype none

module cpr_engine #(
    parameter int MAX_FRAMES = 16,
    parameter int PAGE_BITS  = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire cpr_pkg::cpr_ctrl_t        ctrl,
    input  wire logic [PAGE_BITS-1:0]      page_in,
    input  wire logic [cpr_pkg::CFG_W-1:0] frames_cfg,
    output cpr_pkg::cpr_status_t           status,
    output cpr_pkg::cpr_result_t           result
);

    localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int NW = $clog2(MAX_FRAMES + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic [PAGE_BITS-1:0]        page_reg, page_next;
    logic [IW-1:0]               scan_idx_reg, scan_idx_next;
    logic                        issue_reg, issue_next;
    logic [IW-1:0]               cmp_idx_reg, cmp_idx_next;
    logic                        cmp_vld_reg, cmp_vld_next;
    logic                        hit_reg, hit_next;
    logic [IW-1:0]               slot_reg, slot_next;
    logic [IW-1:0]               hand_reg, hand_next;
    logic [cpr_pkg::FAULT_W-1:0] fault_cnt_reg, fault_cnt_next;
    logic [MAX_FRAMES-1:0]       valid_reg, valid_next;
    logic [MAX_FRAMES-1:0]       use_reg, use_next;

    logic [NW-1:0]        act_n;
    logic [IW-1:0]        last_idx;
    logic                 match;
    logic                 take;
    logic                 ram_we;
    logic [PAGE_BITS-1:0] ram_rdata;

    // Active frame count, with zero acting as one and large values clamped.
    always_comb begin
        if (frames_cfg == '0) begin
            act_n = NW'(1);
        end else if (32'(frames_cfg) > 32'(MAX_FRAMES)) begin
            act_n = NW'(MAX_FRAMES);
        end else begin
            act_n = NW'(frames_cfg);
        end
    end

    assign last_idx = IW'(act_n - NW'(1));

    cpr_page_ram #(
        .DEPTH  (MAX_FRAMES),
        .WIDTH  (PAGE_BITS),
        .ADDR_W (IW)
    ) u_page_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (hand_reg),
        .wr_data (page_reg),
        .rd_addr (scan_idx_reg),
        .rd_data (ram_rdata)
    );

    // The single comparator checks the frame read out in the previous cycle.
    assign match = cmp_vld_reg && valid_reg[cmp_idx_reg] && (ram_rdata == page_reg);
    assign take  = !use_reg[hand_reg];

    always_comb begin
        state_next     = state_reg;
        page_next      = page_reg;
        scan_idx_next  = scan_idx_reg;
        issue_next     = issue_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_vld_next   = cmp_vld_reg;
        hit_next       = hit_reg;
        slot_next      = slot_reg;
        hand_next      = hand_reg;
        fault_cnt_next = fault_cnt_reg;
        valid_next     = valid_reg;
        use_next       = use_reg;
        ram_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (ctrl.start) begin
                    page_next     = page_in;
                    scan_idx_next = '0;
                    issue_next    = 1'b1;
                    cmp_vld_next  = 1'b0;
                    hit_next      = 1'b0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmp_vld_next = issue_reg;
                cmp_idx_next = scan_idx_reg;
                if (issue_reg) begin
                    if (scan_idx_reg == last_idx) begin
                        issue_next = 1'b0;
                    end else begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
                if (match) begin
                    use_next[cmp_idx_reg] = 1'b1;
                    if (!hit_reg) begin
                        slot_next = cmp_idx_reg;
                        hit_next  = 1'b1;
                    end
                end
                if (cmp_vld_reg && (cmp_idx_reg == last_idx)) begin
                    if (match || hit_reg) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SWEEP;
                        if (32'(hand_reg) >= 32'(act_n)) begin
                            hand_next = '0;
                        end
                    end
                end
            end
            ST_SWEEP: begin
                hand_next = (hand_reg == last_idx) ? '0 : hand_reg + 1'b1;
                if (take) begin
                    ram_we               = 1'b1;
                    valid_next[hand_reg] = 1'b1;
                    use_next[hand_reg]   = 1'b1;
                    slot_next            = hand_reg;
                    if (fault_cnt_reg != '1) begin
                        fault_cnt_next = fault_cnt_reg + 1'b1;
                    end
                    state_next = ST_DONE;
                end else begin
                    use_next[hand_reg] = 1'b0;
                end
            end
            ST_DONE: begin
                if (ctrl.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            issue_reg     <= 1'b0;
            cmp_vld_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            hand_reg      <= '0;
            fault_cnt_reg <= '0;
            valid_reg     <= '0;
            use_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            cmp_vld_reg   <= cmp_vld_next;
            hit_reg       <= hit_next;
            hand_reg      <= hand_next;
            fault_cnt_reg <= fault_cnt_next;
            valid_reg     <= valid_next;
            use_reg       <= use_next;
        end
    end

    always_ff @(posedge aclk) begin
        page_reg     <= page_next;
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        slot_reg     <= slot_next;
    end

    assign status.ready = (state_reg == ST_IDLE);
    assign status.done  = (state_reg == ST_DONE) && ctrl.out_free;

    assign result.page_fault  = !hit_reg;
    assign result.frame_slot  = cpr_pkg::SLOT_W'(slot_reg);
    assign result.fault_total = fault_cnt_reg;

    a_start_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.start |-> (state_reg == ST_IDLE))
        else $error("new transaction started while busy");

    a_hand_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |-> (32'(hand_reg) < 32'(act_n)))
        else $error("clock hand outside the active frames during sweep");

    a_slot_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> (valid_reg[slot_reg] && use_reg[slot_reg]))
        else $error("reported frame is not valid with its use bit set");

    a_count_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (fault_cnt_reg >= $past(fault_cnt_reg)))
        else $error("fault count decreased");

endmodule

`default_nettype wire

FILE: sv/clock_page_replacement.sv
// Clock (second-chance) page replacement over up to MAX_FRAMES frames.
//
// Each transaction on the s_ channel carries one referenced page number. The
// block searches the active frames one per cycle through a single comparator
// fed from the page memory. On a hit it sets the use bits of the matching
// frames. On a miss the clock hand then sweeps one frame per cycle, clearing
// set use bits, until it finds a clear one and loads the page there.
// One m_ transaction follows each input with the fault flag, the frame index
// and the saturating fault count.
//
// A hit completes after the serial frame scan; a miss adds the serial hand
// sweep, so both depend on the number of active frames. The sequencer takes
// no new reference until it has finished the current one and passed it on.
// s_ready is high only while the sequencer is idle. A finished result moves to
// an output register, so a new transaction is taken while m_valid waits on
// m_ready; if the output register is still full when the next result is done,
// the sequencer holds it until the receiver takes the pending one.
// Reset empties all frames, clears use bits, hand and fault count, and sets
// the frame count to 3. The register is written through the APB port at byte 0.
`default_nettype none

module clock_page_replacement #(
    parameter int MAX_FRAMES = 16,
    parameter int PAGE_BITS  = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,

    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [PAGE_BITS-1:0]        s_page_number,

    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_page_fault,
    output logic [cpr_pkg::SLOT_W-1:0]       m_frame_slot,
    output logic [cpr_pkg::FAULT_W-1:0]      m_fault_total,

    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [cpr_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [cpr_pkg::APB_W-1:0]   pwdata,
    output logic [cpr_pkg::APB_W-1:0]        prdata,
    output logic                             pready
);

    logic [cpr_pkg::CFG_W-1:0] frames_reg;
    logic                      m_valid_reg;
    cpr_pkg::cpr_result_t      out_reg;

    cpr_pkg::cpr_ctrl_t   ctrl;
    cpr_pkg::cpr_status_t status;
    cpr_pkg::cpr_result_t result;

    logic cfg_write;

    // The register is written in the access phase of an APB write. The word
    // index is taken from address bit 2; other words ignore writes.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == cpr_pkg::REG_FRAMES);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_reg <= cpr_pkg::FRAMES_RESET;
        end else if (cfg_write) begin
            frames_reg <= pwdata[cpr_pkg::CFG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == cpr_pkg::REG_FRAMES) ?
                    cpr_pkg::APB_W'(frames_reg) : '0;

    // The sequencer may deliver a result whenever the output register is empty
    // or is being emptied in this cycle.
    assign ctrl.start    = s_valid && s_ready;
    assign ctrl.out_free = !m_valid_reg || m_ready;

    cpr_engine #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .page_in    (s_page_number),
        .frames_cfg (frames_reg),
        .status     (status),
        .result     (result)
    );

    assign s_ready = status.ready;

    // Output register: separates the result channel from the sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (status.done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (status.done) begin
            out_reg <= result;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_page_fault  = out_reg.page_fault;
    assign m_frame_slot  = out_reg.frame_slot;
    assign m_fault_total = out_reg.fault_total;

endmodule

`default_nettype wire

FILE: tb/tb_clock_page_replacement.sv
`default_nettype none

// Self-checking bench for the clock page replacement block. Every accepted
// reference is run through a predictor that mirrors the frame table, the use
// marks, the hand and the fault counter. Every result transaction is compared
// against the oldest predicted outcome.
module tb_clock_page_replacement;

    // Byte address of the frame count register on the APB port.
    localparam logic [cpr_pkg::ADDR_W-1:0] FRAMES_ADDR =
        cpr_pkg::ADDR_W'(4 * cpr_pkg::REG_FRAMES);

    // Predictor and scoreboard for the frame table. It keeps its own copy of
    // the replacement state and a queue of the outcomes still owed by the block.
    class replacement_tracker;
        logic [15:0]           frame_page [16];
        bit                    frame_valid [16];
        bit                    use_mark [16];
        int unsigned           hand;
        int unsigned           faults;
        logic [4:0]            frames_reg;
        cpr_pkg::cpr_result_t  pending_outcomes [$];
        int unsigned           mismatches;

        function new();
            for (int i = 0; i < 16; i++) begin
                frame_page[i] = '0;
                frame_valid[i] = 1'b0;
                use_mark[i] = 1'b0;
            end
            hand = 0;
            faults = 0;
            frames_reg = cpr_pkg::FRAMES_RESET;
            mismatches = 0;
        endfunction

        function void set_frames(logic [31:0] value);
            frames_reg = value[4:0];
        endfunction

        // A count of zero behaves as one frame, anything above 16 as 16.
        function int unsigned active_count();
            if (frames_reg == 0)
                return 1;
            if (frames_reg > 16)
                return 16;
            return 32'(frames_reg);
        endfunction

        function int unsigned pending();
            return pending_outcomes.size();
        endfunction

        // Applies one accepted reference and queues the outcome it must cause.
        function void note_reference(logic [15:0] page);
            int unsigned n;
            int unsigned slot;
            int unsigned h;
            bit hit;
            bit take;
            cpr_pkg::cpr_result_t outcome;
            n = active_count();
            slot = 0;
            hit = 1'b0;
            // Every matching frame gets its mark; the lowest index is reported.
            for (int i = 0; i < n; i++) begin
                if (frame_valid[i] && frame_page[i] == page) begin
                    if (!hit)
                        slot = i;
                    hit = 1'b1;
                    use_mark[i] = 1'b1;
                end
            end
            if (!hit) begin
                if (hand >= n)
                    hand = 0;
                for (int steps = 0; steps <= n; steps++) begin
                    h = hand;
                    take = !use_mark[h];
                    if (take) begin
                        frame_page[h] = page;
                        frame_valid[h] = 1'b1;
                        use_mark[h] = 1'b1;
                        slot = h;
                    end else begin
                        use_mark[h] = 1'b0;
                    end
                    hand = (h + 1 >= n) ? 0 : h + 1;
                    if (take)
                        break;
                end
                if (faults < 65535)
                    faults++;
            end
            outcome.page_fault = !hit;
            outcome.frame_slot = slot[3:0];
            outcome.fault_total = faults[15:0];
            pending_outcomes.push_back(outcome);
        endfunction

        task report(string what, logic [15:0] got, logic [15:0] want);
            mismatches++;
            $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
        endtask

        task check_outcome(logic fault, logic [3:0] slot, logic [15:0] total);
            cpr_pkg::cpr_result_t want;
            if (pending_outcomes.size() == 0) begin
                report("result with nothing outstanding, slot", 16'(slot), 16'h0);
                return;
            end
            want = pending_outcomes.pop_front();
            if (fault !== want.page_fault)
                report("page_fault", 16'(fault), 16'(want.page_fault));
            if (slot !== want.frame_slot)
                report("frame_slot", 16'(slot), 16'(want.frame_slot));
            if (total !== want.fault_total)
                report("fault_total", total, want.fault_total);
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_page_number;
    logic        m_valid;
    logic        m_ready;
    logic        m_page_fault;
    logic [cpr_pkg::SLOT_W-1:0]  m_frame_slot;
    logic [cpr_pkg::FAULT_W-1:0] m_fault_total;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [cpr_pkg::ADDR_W-1:0] paddr;
    logic [cpr_pkg::APB_W-1:0]  pwdata;
    logic [cpr_pkg::APB_W-1:0]  prdata;
    logic        pready;

    replacement_tracker tracker = new();

    // When set, both sides insert random idle bursts. Cleared for the
    // directed part, for some random phases, and for the final phase.
    bit idling_on = 1'b0;

    // A nonzero value asks the receiver for a long hold of m_ready low, of a
    // length set by the value. The receiver process counts the stretch itself.
    int unsigned rx_hold_request = 0;

    clock_page_replacement #(
        .MAX_FRAMES(16),
        .PAGE_BITS (16)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_page_number(s_page_number),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_page_fault (m_page_fault),
        .m_frame_slot (m_frame_slot),
        .m_fault_total(m_fault_total),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 aclk = ~aclk;

    // Offers one page and returns at the edge where the transaction is taken.
    // The block's outputs are sampled right at the edge, so they still hold the
    // values from before it. Valid stays high if the caller sends again at once.
    task automatic send_page(input logic [15:0] page);
        s_valid <= 1'b1;
        s_page_number <= page;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        tracker.note_reference(page);
    endtask

    // An occasional idle burst on the input side.
    task automatic sender_gap();
        if (idling_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge aclk);
        end
    endtask

    // Stops offering and waits until every predicted outcome has arrived.
    // Every reference yields a result, so the block is idle once that happens.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge aclk);
        repeat (3)
            @(posedge aclk);
    endtask

    // APB write: a setup cycle, then an access cycle. Since pready is always
    // high, the register takes the value at the edge that ends the access.
    task automatic write_frames(input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= FRAMES_ADDR;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        tracker.set_frames(value);
    endtask

    // Most references come from a small window of pages starting at a base. This
    // keeps the working set close to the frame count, so hits, sweeps over set
    // marks and reloads all occur often. The rest are fully random pages or
    // the two extremes of the page field.
    function automatic logic [15:0] pick_page(int unsigned n, logic [15:0] base);
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return base + 16'($urandom_range(0, n + 1));
        if (roll < 8)
            return base + 16'($urandom_range(0, 2 * n + 3));
        if (roll == 8)
            return 16'($urandom);
        return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    endfunction

    // Receiver: checks each result transaction, then decides m_ready for the
    // next cycle. A requested long hold fills the output register and then
    // the sequencer, so the block has to stall its input.
    initial begin : receiver
        int unsigned stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                tracker.check_outcome(m_page_fault, m_frame_slot, m_fault_total);
            if (stall_left == 0 && rx_hold_request > 0) begin
                stall_left = rx_hold_request;
                rx_hold_request = 0;
            end else if (stall_left == 0 && idling_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 12);
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int unsigned n;
        logic [15:0] base;
        int frame_settings [10];

        frame_settings = '{1, 16, 5, 0, 31, 2, 9, 3, 16, 7};
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_page_number <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (11)
            @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, starting from the reset count of three frames. Page
        // zero must miss first, since empty frames never match.
        send_page(16'h0000);
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h5555);
        // All three marks are set here, so the hand clears every one of them
        // and wraps around before it loads the page.
        send_page(16'hAAAA);
        send_page(16'hFFFF);
        send_page(16'h0000);

        // Shrinking to two frames may leave the hand past the active range.
        // The page held in the now inactive frame must not hit.
        drain_results();
        write_frames(32'd2);
        send_page(16'h5555);
        send_page(16'h0001);
        send_page(16'h5555);

        // Growing back to three frames can expose the same page in two frames.
        drain_results();
        write_frames(32'd3);
        send_page(16'h5555);
        send_page(16'h0001);

        // A count of zero behaves as a single frame.
        drain_results();
        write_frames(32'd0);
        send_page(16'h0007);
        send_page(16'h0007);
        send_page(16'h0008);

        // Counts above the frame limit clamp to all sixteen frames.
        drain_results();
        write_frames(32'd31);
        send_page(16'h8000);
        send_page(16'h0001);
        send_page(16'h5555);

        // Only the low five bits of the written word belong to the register.
        drain_results();
        write_frames(32'hFFFF_FFE4);
        send_page(16'h1234);
        send_page(16'hFFFF);

        // Random phases, one per frame count setting. Every fourth phase runs
        // without any idling on either side.
        for (int phase = 0; phase < 10; phase++) begin
            drain_results();
            write_frames(frame_settings[phase]);
            idling_on = (phase % 4 != 3);
            base = (phase % 3 == 0) ? 16'h0000 : 16'($urandom);
            n = tracker.active_count();
            for (int k = 0; k < 90; k++) begin
                // Long receiver hold while the sender keeps offering.
                if (phase == 2 && k == 10)
                    rx_hold_request = 250;
                // The sender pauses until every outstanding result is back.
                if (phase == 6 && k == 40)
                    drain_results();
                send_page(pick_page(n, base));
                sender_gap();
            end
        end

        // Final phase without idling: a single frame and a fresh page on
        // every reference, so each one faults and evicts the previous page.
        // The last two references check a hit and then a miss.
        drain_results();
        idling_on = 1'b0;
        write_frames(32'd1);
        for (int i = 0; i < 40; i++)
            send_page(16'(256 + i));
        send_page(16'(295));
        send_page(16'(296));

        drain_results();
        repeat (40)
            @(posedge aclk);
        if (tracker.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Guard against a hung handshake. The slowest correct run is well under
    // a tenth of this.
    initial begin : watchdog
        #40_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
